// ===== src/mqmr_pkg.sv =====
// ----------------------------------------------------------------------------
// mqmr_pkg: shared types and constants of the multi-queue message ring
// Field widths, operation and status codes, controller/datapath command and
// status groups.
// ----------------------------------------------------------------------------
package mqmr_pkg;

   localparam int QIDX_W    = 2;   // queue_index field
   localparam int BYTE_W    = 8;   // write_byte / read_byte fields
   localparam int LEN_W     = 8;   // length field
   localparam int MSG_LEN_W = 7;   // msg_length field, also stored slot length
   localparam int STATUS_W  = 2;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_READ  = 1'b1
   } mqmr_op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK         = 2'd0,
      STATUS_EMPTY      = 2'd1,
      STATUS_TOO_BIG    = 2'd2,
      STATUS_WRITE_LONG = 2'd3
   } mqmr_status_type;

   // controller -> datapath
   typedef struct packed {
      logic latch_item;   // capture the request payload
      logic clear_step;   // clear one slot descriptor during the sweep
      logic do_write;     // execute a write-byte item
      logic meta_rd;      // read the tail slot descriptor
      logic rd_check;     // evaluate the descriptor, answer or start streaming
      logic byte_rd;      // read the next message byte
      logic byte_load;    // move the fetched byte into the result register
   } mqmr_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_done;   // sweep is at its final entry
      logic item_last;    // latched item carries last_byte
      logic stream_go;    // descriptor says: stream a non-empty message
      logic more;         // streaming and the final byte not yet sent
   } mqmr_sts_type;

endpackage

// ===== src/mqmr_req_if.sv =====
// ----------------------------------------------------------------------------
// mqmr_req_if: request channel
// One write byte or one read request per transfer.
// ----------------------------------------------------------------------------
interface mqmr_req_if;
   logic                              valid;
   logic                              ready;
   logic                              op;
   logic [mqmr_pkg::QIDX_W-1:0]       queue_index;
   logic [mqmr_pkg::BYTE_W-1:0]       write_byte;
   logic [mqmr_pkg::LEN_W-1:0]        length;
   logic                              last_byte;

   modport source (
      output valid, op, queue_index, write_byte, length, last_byte,
      input  ready
   );
   modport sink (
      input  valid, op, queue_index, write_byte, length, last_byte,
      output ready
   );
endinterface

// ===== src/mqmr_rsp_if.sv =====
// ----------------------------------------------------------------------------
// mqmr_rsp_if: response channel
// One status or message byte per transfer.
// ----------------------------------------------------------------------------
interface mqmr_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [mqmr_pkg::STATUS_W-1:0]     status;
   logic [mqmr_pkg::BYTE_W-1:0]       read_byte;
   logic [mqmr_pkg::MSG_LEN_W-1:0]    msg_length;
   logic                              last;

   modport source (
      output valid, status, read_byte, msg_length, last,
      input  ready
   );
   modport sink (
      input  valid, status, read_byte, msg_length, last,
      output ready
   );
endinterface

// ===== src/multi_queue_message_ring.sv =====
// ----------------------------------------------------------------------------
// multi_queue_message_ring: multi-queue message ring buffer
// QUEUES ring queues of SLOTS message slots, MSG_BYTES bytes per slot.
// ----------------------------------------------------------------------------
// After reset the block sweeps its slot descriptors, one per cycle, all
// 2**(clog2(QUEUES)+clog2(SLOTS)) of them (32 at the defaults); req_chan.ready
// stays low meanwhile. A write transfer carries one message byte; the transfer
// marked last_byte commits the message to the queue's head slot and returns
// one status transfer (ok with the length, or write too long when the declared
// length exceeds MSG_BYTES). A read transfer first answers after a descriptor
// memory read, a check, and a byte memory read. An empty tail slot or a
// message larger than the capacity given in length answers with a single
// status transfer; otherwise the message streams out through the registered
// read of the byte memory feeding the output register, each byte read once
// the previous one is transferred, with last on the final byte. One item is
// in work at a time; a new request is taken only after every response of the
// previous one has been transferred. There is no full check: writes past an
// unread slot overwrite it. queue_index wraps modulo QUEUES.
// ----------------------------------------------------------------------------
module multi_queue_message_ring #(
   parameter int QUEUES    = 4,
   parameter int SLOTS     = 8,
   parameter int MSG_BYTES = 64
) (
   input logic         clock,
   input logic         reset,
   mqmr_req_if.sink    req_chan,
   mqmr_rsp_if.source  rsp_chan
);

   mqmr_pkg::mqmr_cmd_type cmd;
   mqmr_pkg::mqmr_sts_type sts;

   logic                              req_ready;
   logic                              rsp_valid;
   logic [mqmr_pkg::STATUS_W-1:0]     rsp_status;
   logic [mqmr_pkg::BYTE_W-1:0]       rsp_read_byte;
   logic [mqmr_pkg::MSG_LEN_W-1:0]    rsp_msg_length;
   logic                              rsp_last;

   // sequencing: sweep, item steps, response drain
   mqmr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_op    (req_chan.op),
      .req_ready (req_ready),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // storage, pointers and the response register
   mqmr_datapath #(
      .QUEUES    (QUEUES),
      .SLOTS     (SLOTS),
      .MSG_BYTES (MSG_BYTES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_queue_index (req_chan.queue_index),
      .req_write_byte  (req_chan.write_byte),
      .req_length      (req_chan.length),
      .req_last_byte   (req_chan.last_byte),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_read_byte   (rsp_read_byte),
      .rsp_msg_length  (rsp_msg_length),
      .rsp_last        (rsp_last)
   );

   assign req_chan.ready      = req_ready;
   assign rsp_chan.valid      = rsp_valid;
   assign rsp_chan.status     = rsp_status;
   assign rsp_chan.read_byte  = rsp_read_byte;
   assign rsp_chan.msg_length = rsp_msg_length;
   assign rsp_chan.last       = rsp_last;

   // a new request is never taken while a response is still pending
   a_ready_no_pending: assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |-> !rsp_chan.valid)
      else $error("request ready while a response is pending");

   // a response appears only from a write commit, a read check or a byte load
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(cmd.do_write || cmd.rd_check || cmd.byte_load))
      else $error("response raised without a producing step");

   // every error or empty status closes its run
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.status != mqmr_pkg::STATUS_OK)) |-> rsp_chan.last)
      else $error("non-ok status without last");

endmodule

// ===== src/mqmr_ctrl.sv =====
// ----------------------------------------------------------------------------
// mqmr_ctrl: sequencing state machine
// Clears the descriptors after reset, then steps each item through the
// datapath and holds off new requests until its results are out.
// ----------------------------------------------------------------------------
module mqmr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_op,
   output logic                  req_ready,
   input  logic                  rsp_ready,
   input  mqmr_pkg::mqmr_sts_type sts,
   output mqmr_pkg::mqmr_cmd_type cmd
);

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_WRITE = 7'b0000100,
      ST_META  = 7'b0001000,
      ST_CHECK = 7'b0010000,
      ST_LOAD  = 7'b0100000,
      ST_DRAIN = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch_item = 1'b1;
               state_in = (req_op == mqmr_pkg::OP_READ) ? ST_META : ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.do_write = 1'b1;
            state_in = sts.item_last ? ST_DRAIN : ST_IDLE;
         end
         ST_META: begin
            cmd.meta_rd = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.rd_check = 1'b1;
            if (sts.stream_go) begin
               cmd.byte_rd = 1'b1;
               state_in = ST_LOAD;
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_LOAD: begin
            cmd.byte_load = 1'b1;
            state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (rsp_ready) begin
               if (sts.more) begin
                  cmd.byte_rd = 1'b1;
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/mqmr_datapath.sv =====
// ----------------------------------------------------------------------------
// mqmr_datapath: pointers, slot stores and result register
// Descriptor memory {full, length} per slot, byte memory per slot position,
// head/tail pointers per queue, write progress and the output register.
// ----------------------------------------------------------------------------
module mqmr_datapath #(
   parameter int QUEUES    = 4,
   parameter int SLOTS     = 8,
   parameter int MSG_BYTES = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mqmr_pkg::mqmr_cmd_type              cmd,
   output mqmr_pkg::mqmr_sts_type              sts,
   input  logic [mqmr_pkg::QIDX_W-1:0]         req_queue_index,
   input  logic [mqmr_pkg::BYTE_W-1:0]         req_write_byte,
   input  logic [mqmr_pkg::LEN_W-1:0]          req_length,
   input  logic                                req_last_byte,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [mqmr_pkg::STATUS_W-1:0]       rsp_status,
   output logic [mqmr_pkg::BYTE_W-1:0]         rsp_read_byte,
   output logic [mqmr_pkg::MSG_LEN_W-1:0]      rsp_msg_length,
   output logic                                rsp_last
);

   localparam int QW      = (QUEUES > 1) ? $clog2(QUEUES) : 1;
   localparam int SW      = $clog2(SLOTS);
   localparam int BW      = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;
   localparam int META_AW = QW + SW;
   localparam int BYTE_AW = META_AW + BW;
   localparam int ML      = mqmr_pkg::MSG_LEN_W;
   localparam int BYW     = mqmr_pkg::BYTE_W;
   localparam int LW      = mqmr_pkg::LEN_W;

   localparam logic [2:0]    QMOD      = 3'((QUEUES < 4) ? QUEUES : 4);
   localparam logic [SW-1:0] SLOT_LAST = SW'(SLOTS - 1);
   localparam logic [ML-1:0] MB_ML     = ML'(MSG_BYTES);
   localparam logic [LW-1:0] MB_LW     = LW'(MSG_BYTES);
   localparam logic [ML-1:0] ONE_ML    = ML'(1);

   // memories
   logic [ML:0]      meta_mem [2**META_AW];
   logic [BYW-1:0]   byte_mem [2**BYTE_AW];

   // control state
   logic [SW-1:0]      head_ff [QUEUES];
   logic [SW-1:0]      head_in [QUEUES];
   logic [SW-1:0]      tail_ff [QUEUES];
   logic [SW-1:0]      tail_in [QUEUES];
   logic [ML-1:0]      wcount_ff, wcount_in;
   logic               wreject_ff, wreject_in;
   logic [META_AW-1:0] clr_addr_ff, clr_addr_in;
   logic               stream_ff, stream_in;
   logic               out_valid_ff, out_valid_in;

   // item and working registers
   logic [QW-1:0]      q_ff, q_in;
   logic [BYW-1:0]     wbyte_ff, wbyte_in;
   logic [LW-1:0]      len_ff, len_in;
   logic               lastb_ff, lastb_in;
   logic [META_AW-1:0] slot_ff, slot_in;
   logic [ML-1:0]      n_ff, n_in;
   logic [ML-1:0]      rd_idx_ff, rd_idx_in;
   logic [ML:0]        meta_q_ff;
   logic [BYW-1:0]     byte_q_ff;

   logic [mqmr_pkg::STATUS_W-1:0] out_status_ff, out_status_in;
   logic [BYW-1:0]                out_byte_ff, out_byte_in;
   logic [ML-1:0]                 out_len_ff, out_len_in;
   logic                          out_last_ff, out_last_in;

   // combinational helpers
   logic [1:0]         q_red;
   logic               meta_full;
   logic [ML-1:0]      meta_n;
   logic               too_big;
   logic               reject_now;
   logic               store_byte;
   logic               meta_we;
   logic [META_AW-1:0] meta_wa;
   logic [ML:0]        meta_wd;
   logic               byte_we;
   logic [BYTE_AW-1:0] byte_wa;
   logic [BYTE_AW-1:0] byte_ra;
   logic [META_AW-1:0] tail_slot;
   logic [META_AW-1:0] head_slot;

   // queue_index modulo QUEUES: at most three compare-subtract steps
   always_comb begin
      q_red = req_queue_index;
      for (int k = 0; k < 3; k++) begin
         if ({1'b0, q_red} >= QMOD) begin
            q_red = q_red - QMOD[1:0];
         end
      end
   end

   assign meta_full  = meta_q_ff[ML];
   assign meta_n     = meta_q_ff[ML-1:0];
   assign too_big    = {1'b0, meta_n} > len_ff;
   assign reject_now = wreject_ff || (len_ff > MB_LW);
   assign store_byte = ({1'b0, wcount_ff} < len_ff) && (wcount_ff < MB_ML);
   assign head_slot  = {q_ff, head_ff[q_ff]};
   assign tail_slot  = {q_ff, tail_ff[q_ff]};
   assign byte_wa    = {head_slot, wcount_ff[BW-1:0]};
   assign byte_ra    = {slot_ff, rd_idx_ff[BW-1:0]};
   assign byte_we    = cmd.do_write && store_byte;

   // descriptor write port: sweep, commit, or release after a good read
   always_comb begin
      meta_we = 1'b0;
      meta_wa = slot_ff;
      meta_wd = {1'b0, meta_n};
      priority if (cmd.clear_step) begin
         meta_we = 1'b1;
         meta_wa = clr_addr_ff;
         meta_wd = '0;
      end else if (cmd.do_write && lastb_ff && !reject_now) begin
         meta_we = 1'b1;
         meta_wa = head_slot;
         meta_wd = {1'b1, len_ff[ML-1:0]};
      end else if (cmd.rd_check && meta_full && !too_big) begin
         meta_we = 1'b1;
      end else begin
         meta_we = 1'b0;
      end
   end

   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      wcount_in     = wcount_ff;
      wreject_in    = wreject_ff;
      clr_addr_in   = clr_addr_ff;
      stream_in     = stream_ff;
      out_valid_in  = out_valid_ff;
      q_in          = q_ff;
      wbyte_in      = wbyte_ff;
      len_in        = len_ff;
      lastb_in      = lastb_ff;
      slot_in       = slot_ff;
      n_in          = n_ff;
      rd_idx_in     = rd_idx_ff;
      out_status_in = out_status_ff;
      out_byte_in   = out_byte_ff;
      out_len_in    = out_len_ff;
      out_last_in   = out_last_ff;

      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end

      if (cmd.clear_step) begin
         clr_addr_in = clr_addr_ff + META_AW'(1);
      end

      if (cmd.latch_item) begin
         q_in      = QW'(q_red);
         wbyte_in  = req_write_byte;
         len_in    = req_length;
         lastb_in  = req_last_byte;
         stream_in = 1'b0;
      end

      if (cmd.do_write) begin
         if (lastb_ff) begin
            wcount_in    = '0;
            wreject_in   = 1'b0;
            out_valid_in = 1'b1;
            out_byte_in  = '0;
            out_last_in  = 1'b1;
            if (reject_now) begin
               out_status_in = mqmr_pkg::STATUS_WRITE_LONG;
               out_len_in    = '0;
            end else begin
               out_status_in = mqmr_pkg::STATUS_OK;
               out_len_in    = len_ff[ML-1:0];
               head_in[q_ff] = (head_ff[q_ff] == SLOT_LAST) ? '0 :
                               head_ff[q_ff] + SW'(1);
            end
         end else begin
            wreject_in = reject_now;
            if (wcount_ff < MB_ML) begin
               wcount_in = wcount_ff + ONE_ML;
            end
         end
      end

      if (cmd.meta_rd) begin
         slot_in   = tail_slot;
         rd_idx_in = '0;
      end

      if (cmd.rd_check) begin
         n_in = meta_n;
         if (!meta_full) begin
            out_valid_in  = 1'b1;
            out_status_in = mqmr_pkg::STATUS_EMPTY;
            out_byte_in   = '0;
            out_len_in    = '0;
            out_last_in   = 1'b1;
         end else if (too_big) begin
            out_valid_in  = 1'b1;
            out_status_in = mqmr_pkg::STATUS_TOO_BIG;
            out_byte_in   = '0;
            out_len_in    = meta_n;
            out_last_in   = 1'b1;
         end else begin
            tail_in[q_ff] = (tail_ff[q_ff] == SLOT_LAST) ? '0 :
                            tail_ff[q_ff] + SW'(1);
            if (meta_n == '0) begin
               out_valid_in  = 1'b1;
               out_status_in = mqmr_pkg::STATUS_OK;
               out_byte_in   = '0;
               out_len_in    = '0;
               out_last_in   = 1'b1;
            end else begin
               stream_in = 1'b1;
            end
         end
      end

      if (cmd.byte_load) begin
         out_valid_in  = 1'b1;
         out_status_in = mqmr_pkg::STATUS_OK;
         out_byte_in   = byte_q_ff;
         out_len_in    = n_ff;
         out_last_in   = (rd_idx_ff + ONE_ML) == n_ff;
         rd_idx_in     = rd_idx_ff + ONE_ML;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < QUEUES; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
         end
         wcount_ff    <= '0;
         wreject_ff   <= 1'b0;
         clr_addr_ff  <= '0;
         stream_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         wcount_ff    <= wcount_in;
         wreject_ff   <= wreject_in;
         clr_addr_ff  <= clr_addr_in;
         stream_ff    <= stream_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff          <= q_in;
      wbyte_ff      <= wbyte_in;
      len_ff        <= len_in;
      lastb_ff      <= lastb_in;
      slot_ff       <= slot_in;
      n_ff          <= n_in;
      rd_idx_ff     <= rd_idx_in;
      out_status_ff <= out_status_in;
      out_byte_ff   <= out_byte_in;
      out_len_ff    <= out_len_in;
      out_last_ff   <= out_last_in;
   end

   // descriptor memory
   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[meta_wa] <= meta_wd;
      end
      if (cmd.meta_rd) begin
         meta_q_ff <= meta_mem[tail_slot];
      end
   end

   // message byte memory
   always_ff @(posedge clock) begin
      if (byte_we) begin
         byte_mem[byte_wa] <= wbyte_ff;
      end
      if (cmd.byte_rd) begin
         byte_q_ff <= byte_mem[byte_ra];
      end
   end

   assign sts.clear_done = (clr_addr_ff == '1);
   assign sts.item_last  = lastb_ff;
   assign sts.stream_go  = meta_full && !too_big && (meta_n != '0);
   assign sts.more       = stream_ff && !out_last_ff;

   assign rsp_valid      = out_valid_ff;
   assign rsp_status     = out_status_ff;
   assign rsp_read_byte  = out_byte_ff;
   assign rsp_msg_length = out_len_ff;
   assign rsp_last       = out_last_ff;

endmodule
